### sv/emfp_pkg.sv
// Shared types, fixed-point constants and the arctangent table of the essential matrix block.
`timescale 1ns / 1ps
`default_nettype none

package emfp_pkg;

    localparam int ANGLE_ITERATIONS = 24;
    localparam int CORDIC_STEPS = (ANGLE_ITERATIONS < 32) ? ANGLE_ITERATIONS : 32;

    localparam int EW = 34;
    typedef logic signed [EW-1:0] ent_t;
    typedef ent_t [0:2][0:2] mat_t;

    localparam ent_t Q30_ONE     = 34'sd1073741824;
    localparam ent_t Q30_PI      = 34'sd3373259426;
    localparam ent_t Q30_HALF_PI = 34'sd1686629713;
    localparam ent_t CORDIC_GAIN = 34'sd652032874;
    localparam logic [63:0] ROUND_HALF = 64'd536870912;

    // Entries are floor(atan(2^-i) * 2^30).
    function automatic ent_t atan_q30(input int idx);
        ent_t v;
        case (idx)
            0: v = 34'sd843314856;
            1: v = 34'sd497837829;
            2: v = 34'sd263043836;
            3: v = 34'sd133525158;
            4: v = 34'sd67021686;
            5: v = 34'sd33543515;
            6: v = 34'sd16775850;
            7: v = 34'sd8388437;
            8: v = 34'sd4194282;
            9: v = 34'sd2097149;
            10: v = 34'sd1048575;
            11: v = 34'sd524287;
            12: v = 34'sd262143;
            13: v = 34'sd131071;
            14: v = 34'sd65535;
            15: v = 34'sd32767;
            16: v = 34'sd16383;
            17: v = 34'sd8191;
            18: v = 34'sd4095;
            19: v = 34'sd2047;
            20: v = 34'sd1023;
            21: v = 34'sd511;
            22: v = 34'sd255;
            23: v = 34'sd127;
            24: v = 34'sd63;
            25: v = 34'sd31;
            26: v = 34'sd15;
            27: v = 34'sd7;
            28: v = 34'sd3;
            29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/essential_matrix_from_poses.sv
// Top level: pipelined essential matrix from two camera poses.
//
// One command channel in, one strobed result channel out. A pose pair is
// taken at every rising edge with start high and busy low; busy stays low,
// so a new item may be issued in every cycle.
// Each item yields one result on the e_* ports and zero_baseline, shown for
// exactly one cycle with done high.
// Throughput is one item per cycle. The latency is set by the baseline
// path: a 31-step square root and a 31-step division, one step per stage.
// The six sine/cosine units run 24 CORDIC stages and start late so that
// the rotations meet the unit baseline at the same stage.
// Reset clears only the valid bits of the pipeline; items in flight are
// dropped and no strobe follows until new items arrive.
// The receiver cannot hold results off, so nothing in the pipeline stalls.
// A zero baseline gives all-zero entries with zero_baseline set.
`timescale 1ns / 1ps
`default_nettype none

module essential_matrix_from_poses (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [39:0] left_pos_x,
    input  logic signed [39:0] left_pos_y,
    input  logic signed [39:0] left_pos_z,
    input  logic signed [23:0] left_omega,
    input  logic signed [23:0] left_phi,
    input  logic signed [23:0] left_kappa,
    input  logic signed [39:0] right_pos_x,
    input  logic signed [39:0] right_pos_y,
    input  logic signed [39:0] right_pos_z,
    input  logic signed [23:0] right_omega,
    input  logic signed [23:0] right_phi,
    input  logic signed [23:0] right_kappa,
    output logic               done,
    output logic signed [31:0] e_row0_col0,
    output logic signed [31:0] e_row0_col1,
    output logic signed [31:0] e_row0_col2,
    output logic signed [31:0] e_row1_col0,
    output logic signed [31:0] e_row1_col1,
    output logic signed [31:0] e_row1_col2,
    output logic signed [31:0] e_row2_col0,
    output logic signed [31:0] e_row2_col1,
    output logic signed [31:0] e_row2_col2,
    output logic               zero_baseline
);

    localparam int CITER   = emfp_pkg::CORDIC_STEPS;
    localparam int S_SUM   = 5;
    localparam int S_ROOT  = S_SUM + 31;
    localparam int S_DIVIN = S_ROOT + 1;
    localparam int S_QUOT  = S_DIVIN + 31;
    localparam int S_UNIT  = S_QUOT + 1;
    localparam int S_T     = S_UNIT + 2;
    localparam int S_E     = S_T + 2;
    localparam int LAT     = S_E + 1;
    localparam int C0      = S_UNIT - CITER - 5;

    // ---------------- valid bits ----------------
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start};
        end
    end

    assign busy = 1'b0;
    assign done = vld_reg[LAT-1];

    // ---------------- baseline path ----------------
    logic [40:0] dif [0:2];
    logic [39:0] mag_next [0:2];
    logic [3:0]  flg_next;
    logic [39:0] mag1_reg [0:2];
    logic [39:0] mag2_reg [0:2];
    logic [5:0]  len_next;
    logic [5:0]  len_reg;
    logic [29:0] mag3_next [0:2];
    logic [29:0] mag3_reg [0:2];
    logic [59:0] sq4_reg [0:2];
    logic [29:0] magd_reg [4:S_ROOT][0:2];
    logic [3:0]  flg_reg [1:S_E];
    logic [61:0] sqx_next [S_SUM+1:S_ROOT];
    logic [61:0] sqr_next [S_SUM+1:S_ROOT];
    logic [61:0] sqx_reg [S_SUM:S_ROOT];
    logic [61:0] sqr_reg [S_SUM:S_ROOT];
    logic [30:0] dd_reg  [S_DIVIN:S_QUOT];
    logic [60:0] rem_reg [S_DIVIN:S_QUOT][0:2];
    logic [30:0] quo_reg [S_DIVIN:S_QUOT][0:2];
    logic [60:0] rem_next [S_DIVIN+1:S_QUOT][0:2];
    logic [30:0] quo_next [S_DIVIN+1:S_QUOT][0:2];
    logic [60:0] num_next [0:2];
    emfp_pkg::ent_t u_next [0:2];
    emfp_pkg::ent_t u_reg  [0:2];

    always_comb
    begin
        logic [40:0] ab;
        dif[0] = {right_pos_x[39], right_pos_x} - {left_pos_x[39], left_pos_x};
        dif[1] = {right_pos_y[39], right_pos_y} - {left_pos_y[39], left_pos_y};
        dif[2] = {right_pos_z[39], right_pos_z} - {left_pos_z[39], left_pos_z};
        for (int i = 0; i < 3; i++)
        begin
            ab = dif[i][40] ? (41'd0 - dif[i]) : dif[i];
            mag_next[i] = ab[39:0];
            flg_next[i] = dif[i][40];
        end
        flg_next[3] = (dif[0] == 41'd0) && (dif[1] == 41'd0) && (dif[2] == 41'd0);
    end

    // Bit length of the largest magnitude equals that of the OR of all three.
    always_comb
    begin
        logic [39:0] any;
        any = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        len_next = '0;
        for (int b = 0; b < 40; b++)
        begin
            if (any[b])
            begin
                len_next = 6'(b + 1);
            end
        end
    end

    always_comb
    begin
        logic [39:0] sv;
        for (int i = 0; i < 3; i++)
        begin
            if (len_reg > 6'd30)
            begin
                sv = mag2_reg[i] >> (len_reg - 6'd30);
            end
            else
            begin
                sv = mag2_reg[i] << (6'd30 - len_reg);
            end
            mag3_next[i] = sv[29:0];
        end
    end

    // Integer square root, one result bit per stage.
    always_comb
    begin
        logic [61:0] bitv;
        logic [61:0] trial;
        for (int s = S_SUM + 1; s <= S_ROOT; s++)
        begin
            bitv  = 62'd1 << (60 - 2 * (s - S_SUM - 1));
            trial = sqr_reg[s-1] + bitv;
            if (sqx_reg[s-1] >= trial)
            begin
                sqx_next[s] = sqx_reg[s-1] - trial;
                sqr_next[s] = (sqr_reg[s-1] >> 1) + bitv;
            end
            else
            begin
                sqx_next[s] = sqx_reg[s-1];
                sqr_next[s] = sqr_reg[s-1] >> 1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = {1'b0, magd_reg[S_ROOT][i], 30'd0}
                        + {30'd0, sqr_reg[S_ROOT][31:1]};
        end
    end

    // Restoring division, one quotient bit per stage.
    always_comb
    begin
        logic [61:0] dsh;
        for (int s = S_DIVIN + 1; s <= S_QUOT; s++)
        begin
            dsh = {31'd0, dd_reg[s-1]} << (S_QUOT - s);
            for (int i = 0; i < 3; i++)
            begin
                if ({1'b0, rem_reg[s-1][i]} >= dsh)
                begin
                    rem_next[s][i] = rem_reg[s-1][i] - dsh[60:0];
                    quo_next[s][i] = {quo_reg[s-1][i][29:0], 1'b1};
                end
                else
                begin
                    rem_next[s][i] = rem_reg[s-1][i];
                    quo_next[s][i] = {quo_reg[s-1][i][29:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        emfp_pkg::ent_t q;
        for (int i = 0; i < 3; i++)
        begin
            q = emfp_pkg::ent_t'({3'd0, quo_reg[S_QUOT][i]});
            u_next[i] = flg_reg[S_UNIT-1][i] ? -q : q;
        end
    end

    always_ff @(posedge clk)
    begin
        flg_reg[1] <= flg_next;
        for (int s = 2; s <= S_E; s++)
        begin
            flg_reg[s] <= flg_reg[s-1];
        end
        mag1_reg <= mag_next;
        mag2_reg <= mag1_reg;
        len_reg  <= len_next;
        mag3_reg <= mag3_next;
        for (int i = 0; i < 3; i++)
        begin
            sq4_reg[i]     <= 60'(mag3_reg[i] * mag3_reg[i]);
            magd_reg[4][i] <= mag3_reg[i];
        end
        for (int s = 5; s <= S_ROOT; s++)
        begin
            magd_reg[s] <= magd_reg[s-1];
        end
        sqx_reg[S_SUM] <= {2'd0, sq4_reg[0]} + {2'd0, sq4_reg[1]} + {2'd0, sq4_reg[2]};
        sqr_reg[S_SUM] <= '0;
        for (int s = S_SUM + 1; s <= S_ROOT; s++)
        begin
            sqx_reg[s] <= sqx_next[s];
            sqr_reg[s] <= sqr_next[s];
        end
        dd_reg[S_DIVIN] <= sqr_reg[S_ROOT][30:0];
        for (int i = 0; i < 3; i++)
        begin
            rem_reg[S_DIVIN][i] <= num_next[i];
            quo_reg[S_DIVIN][i] <= '0;
        end
        for (int s = S_DIVIN + 1; s <= S_QUOT; s++)
        begin
            dd_reg[s]  <= dd_reg[s-1];
            rem_reg[s] <= rem_next[s];
            quo_reg[s] <= quo_next[s];
        end
        u_reg <= u_next;
    end

    // ---------------- sine and cosine, six lanes ----------------
    logic [23:0] ang_reg [1:C0-1][0:5];
    emfp_pkg::ent_t cx_reg [0:CITER][0:5];
    emfp_pkg::ent_t cy_reg [0:CITER][0:5];
    emfp_pkg::ent_t cz_reg [0:CITER][0:5];
    logic [5:0]     cf_reg [0:CITER];
    emfp_pkg::ent_t cx_next [1:CITER][0:5];
    emfp_pkg::ent_t cy_next [1:CITER][0:5];
    emfp_pkg::ent_t cz_next [1:CITER][0:5];
    emfp_pkg::ent_t z0_next [0:5];
    logic [5:0]     f0_next;
    emfp_pkg::ent_t sin_reg [0:5];
    emfp_pkg::ent_t cos_reg [0:5];

    always_comb
    begin
        emfp_pkg::ent_t zw;
        for (int l = 0; l < 6; l++)
        begin
            zw = emfp_pkg::ent_t'($signed(ang_reg[C0-1][l])) <<< 9;
            f0_next[l] = 1'b0;
            z0_next[l] = zw;
            if (zw > emfp_pkg::Q30_HALF_PI)
            begin
                z0_next[l] = zw - emfp_pkg::Q30_PI;
                f0_next[l] = 1'b1;
            end
            else if (zw < -emfp_pkg::Q30_HALF_PI)
            begin
                z0_next[l] = zw + emfp_pkg::Q30_PI;
                f0_next[l] = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < CITER; i++)
        begin
            for (int l = 0; l < 6; l++)
            begin
                if (!cz_reg[i][l][emfp_pkg::EW-1])
                begin
                    cx_next[i+1][l] = cx_reg[i][l] - (cy_reg[i][l] >>> i);
                    cy_next[i+1][l] = cy_reg[i][l] + (cx_reg[i][l] >>> i);
                    cz_next[i+1][l] = cz_reg[i][l] - emfp_pkg::atan_q30(i);
                end
                else
                begin
                    cx_next[i+1][l] = cx_reg[i][l] + (cy_reg[i][l] >>> i);
                    cy_next[i+1][l] = cy_reg[i][l] - (cx_reg[i][l] >>> i);
                    cz_next[i+1][l] = cz_reg[i][l] + emfp_pkg::atan_q30(i);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ang_reg[1][0] <= left_omega;
        ang_reg[1][1] <= left_phi;
        ang_reg[1][2] <= left_kappa;
        ang_reg[1][3] <= right_omega;
        ang_reg[1][4] <= right_phi;
        ang_reg[1][5] <= right_kappa;
        for (int s = 2; s < C0; s++)
        begin
            ang_reg[s] <= ang_reg[s-1];
        end
        for (int l = 0; l < 6; l++)
        begin
            cx_reg[0][l] <= emfp_pkg::CORDIC_GAIN;
            cy_reg[0][l] <= '0;
        end
        cz_reg[0] <= z0_next;
        cf_reg[0] <= f0_next;
        for (int i = 1; i <= CITER; i++)
        begin
            cx_reg[i] <= cx_next[i];
            cy_reg[i] <= cy_next[i];
            cz_reg[i] <= cz_next[i];
            cf_reg[i] <= cf_reg[i-1];
        end
        for (int l = 0; l < 6; l++)
        begin
            sin_reg[l] <= cf_reg[CITER][l] ? -cy_reg[CITER][l] : cy_reg[CITER][l];
            cos_reg[l] <= cf_reg[CITER][l] ? -cx_reg[CITER][l] : cx_reg[CITER][l];
        end
    end

    // ---------------- rotations and products ----------------
    emfp_pkg::mat_t rx_m [0:1];
    emfp_pkg::mat_t ry_m [0:1];
    emfp_pkg::mat_t rz_m [0:1];
    emfp_pkg::mat_t rz1_reg [0:1];
    emfp_pkg::mat_t rz2_reg [0:1];
    emfp_pkg::mat_t xy_m [0:1];
    emfp_pkg::mat_t rot_m [0:1];
    emfp_pkg::mat_t rr1_reg;
    emfp_pkg::mat_t rr2_reg;
    emfp_pkg::mat_t skew_m;
    emfp_pkg::mat_t t_m;
    emfp_pkg::mat_t e_m;

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            rx_m[c] = '0;
            ry_m[c] = '0;
            rz_m[c] = '0;
            rx_m[c][0][0] = emfp_pkg::Q30_ONE;
            rx_m[c][1][1] = cos_reg[3*c];
            rx_m[c][1][2] = -sin_reg[3*c];
            rx_m[c][2][1] = sin_reg[3*c];
            rx_m[c][2][2] = cos_reg[3*c];
            ry_m[c][0][0] = cos_reg[3*c+1];
            ry_m[c][0][2] = sin_reg[3*c+1];
            ry_m[c][1][1] = emfp_pkg::Q30_ONE;
            ry_m[c][2][0] = -sin_reg[3*c+1];
            ry_m[c][2][2] = cos_reg[3*c+1];
            rz_m[c][0][0] = cos_reg[3*c+2];
            rz_m[c][0][1] = -sin_reg[3*c+2];
            rz_m[c][1][0] = sin_reg[3*c+2];
            rz_m[c][1][1] = cos_reg[3*c+2];
            rz_m[c][2][2] = emfp_pkg::Q30_ONE;
        end
        skew_m = '0;
        skew_m[0][1] = -u_reg[2];
        skew_m[0][2] = u_reg[1];
        skew_m[1][0] = u_reg[2];
        skew_m[1][2] = -u_reg[0];
        skew_m[2][0] = -u_reg[1];
        skew_m[2][1] = u_reg[0];
    end

    always_ff @(posedge clk)
    begin
        rz1_reg <= rz_m;
        rz2_reg <= rz1_reg;
        rr1_reg <= rot_m[1];
        rr2_reg <= rr1_reg;
    end

    emfp_matmul u_xy_left  (.clk(clk), .transpose_a(1'b0), .a(rx_m[0]), .b(ry_m[0]),
                            .c(xy_m[0]));
    emfp_matmul u_xy_right (.clk(clk), .transpose_a(1'b0), .a(rx_m[1]), .b(ry_m[1]),
                            .c(xy_m[1]));
    emfp_matmul u_rot_left (.clk(clk), .transpose_a(1'b0), .a(xy_m[0]), .b(rz2_reg[0]),
                            .c(rot_m[0]));
    emfp_matmul u_rot_right(.clk(clk), .transpose_a(1'b0), .a(xy_m[1]), .b(rz2_reg[1]),
                            .c(rot_m[1]));
    emfp_matmul u_lt_skew  (.clk(clk), .transpose_a(1'b1), .a(rot_m[0]), .b(skew_m),
                            .c(t_m));
    emfp_matmul u_ess      (.clk(clk), .transpose_a(1'b0), .a(t_m), .b(rr2_reg),
                            .c(e_m));

    // ---------------- output register ----------------
    logic signed [31:0] out_next [0:8];
    logic signed [31:0] out_reg  [0:8];
    logic               zb_reg;

    always_comb
    begin
        emfp_pkg::ent_t v;
        for (int k = 0; k < 9; k++)
        begin
            v = e_m[k/3][k%3];
            if (flg_reg[S_E][3])
            begin
                out_next[k] = '0;
            end
            else if (v > 34'sd2147483647)
            begin
                out_next[k] = 32'sh7fffffff;
            end
            else
            begin
                out_next[k] = v[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        zb_reg  <= flg_reg[S_E][3];
    end

    assign e_row0_col0   = out_reg[0];
    assign e_row0_col1   = out_reg[1];
    assign e_row0_col2   = out_reg[2];
    assign e_row1_col0   = out_reg[3];
    assign e_row1_col1   = out_reg[4];
    assign e_row1_col2   = out_reg[5];
    assign e_row2_col0   = out_reg[6];
    assign e_row2_col1   = out_reg[7];
    assign e_row2_col2   = out_reg[8];
    assign zero_baseline = zb_reg;

endmodule

`default_nettype wire

### sv/emfp_matmul.sv
// Two-stage pipelined 3x3 Q30 matrix product with optional transpose of the left operand.
`timescale 1ns / 1ps
`default_nettype none

module emfp_matmul (
    input  logic            clk,
    input  logic            transpose_a,
    input  emfp_pkg::mat_t  a,
    input  emfp_pkg::mat_t  b,
    output emfp_pkg::mat_t  c
);

    localparam logic signed [63:0] LIM_HI = 64'sd2147483648;
    localparam logic signed [63:0] LIM_LO = -64'sd2147483648;

    logic [63:0] prd_next [0:2][0:2][0:2];
    logic [63:0] prd_reg  [0:2][0:2][0:2];
    emfp_pkg::mat_t c_next;
    emfp_pkg::mat_t c_reg;

    always_comb
    begin
        logic signed [67:0] full;
        emfp_pkg::ent_t av;
        for (int r = 0; r < 3; r++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    av = transpose_a ? a[k][r] : a[r][k];
                    full = $signed(av) * $signed(b[k][j]);
                    prd_next[r][j][k] = full[63:0];
                end
            end
        end
    end

    // The sum wraps at 64 bits, then rounds half up and saturates.
    always_comb
    begin
        logic [63:0] acc;
        logic signed [63:0] sh;
        for (int r = 0; r < 3; r++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                acc = prd_reg[r][j][0] + prd_reg[r][j][1] + prd_reg[r][j][2]
                    + emfp_pkg::ROUND_HALF;
                sh = $signed(acc) >>> 30;
                if (sh > LIM_HI)
                begin
                    sh = LIM_HI;
                end
                else if (sh < LIM_LO)
                begin
                    sh = LIM_LO;
                end
                c_next[r][j] = sh[emfp_pkg::EW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prd_reg <= prd_next;
        c_reg   <= c_next;
    end

    assign c = c_reg;

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the essential matrix block with a built-in predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY = 74;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1650;
    localparam int NDIR = 14;
    localparam longint POS_MAX = 64'sd549755813887;
    localparam longint POS_MIN = -64'sd549755813888;
    localparam longint ANG_MAX = 64'sd8388607;
    localparam longint ANG_MIN = -64'sd8388608;

    typedef struct {
        longint pos [6];    // left x,y,z then right x,y,z
        longint ang [6];    // left omega,phi,kappa then right
    } pose_pair_t;

    typedef struct {
        logic signed [31:0] ent [9];
        logic zb;
    } ematrix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [39:0] lpx = '0, lpy = '0, lpz = '0, rpx = '0, rpy = '0, rpz = '0;
    logic signed [23:0] lom = '0, lph = '0, lka = '0, rom = '0, rph = '0, rka = '0;
    logic done;
    logic signed [31:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic zbl;

    ematrix_t expected_q [$];
    int mismatches = 0;
    int stall_cycles = 0;
    int zero_count = 0;
    int checked = 0;
    // Row of the stimulus table being driven, or -1 for a random item.
    int drive_row = -1;

    pose_pair_t directed [NDIR];
    bit dir_typed [NDIR];
    ematrix_t dir_exp [NDIR];

    always #1 clk = ~clk;

    essential_matrix_from_poses dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .left_pos_x(lpx), .left_pos_y(lpy), .left_pos_z(lpz),
        .left_omega(lom), .left_phi(lph), .left_kappa(lka),
        .right_pos_x(rpx), .right_pos_y(rpy), .right_pos_z(rpz),
        .right_omega(rom), .right_phi(rph), .right_kappa(rka),
        .done(done),
        .e_row0_col0(e00), .e_row0_col1(e01), .e_row0_col2(e02),
        .e_row1_col0(e10), .e_row1_col1(e11), .e_row1_col2(e12),
        .e_row2_col0(e20), .e_row2_col1(e21), .e_row2_col2(e22),
        .zero_baseline(zbl)
    );

    function automatic longint shift_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void cordic_sin_cos(longint a21, output longint sn, output longint cs);
        longint z, x, y, nx;
        bit flip;
        z = a21 * 512;
        x = emfp_pkg::CORDIC_GAIN;
        y = 0;
        flip = 0;
        if (z > longint'(emfp_pkg::Q30_HALF_PI))
        begin
            z -= emfp_pkg::Q30_PI;
            flip = 1;
        end
        else if (z < -longint'(emfp_pkg::Q30_HALF_PI))
        begin
            z += emfp_pkg::Q30_PI;
            flip = 1;
        end
        for (int i = 0; i < emfp_pkg::CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - shift_floor(y, i);
                y = y + shift_floor(x, i);
                z -= emfp_pkg::atan_q30(i);
            end
            else
            begin
                nx = x + shift_floor(y, i);
                y = y - shift_floor(x, i);
                z += emfp_pkg::atan_q30(i);
            end
            x = nx;
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    // Products wrap at 64 bits before the rounding shift, as the hardware sums do.
    function automatic void q30_product(output longint c [3][3], input longint a [3][3],
                                        input longint b [3][3], input bit ta);
        longint acc, av, v;
        for (int r = 0; r < 3; r++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 64'sd536870912;
                for (int k = 0; k < 3; k++)
                begin
                    av = ta ? a[k][r] : a[r][k];
                    acc += av * b[k][j];
                end
                v = acc >>> 30;
                if (v < -64'sd2147483648) v = -64'sd2147483648;
                if (v > 64'sd2147483648) v = 64'sd2147483648;
                c[r][j] = v;
            end
    endfunction

    function automatic void camera_rotation(longint om, longint ph, longint ka,
                                            output longint r [3][3]);
        longint so, co, sp, cp, sk, ck, one;
        longint rx [3][3], ry [3][3], rz [3][3], t [3][3];
        one = 64'sd1073741824;
        cordic_sin_cos(om, so, co);
        cordic_sin_cos(ph, sp, cp);
        cordic_sin_cos(ka, sk, ck);
        rx = '{'{one, 0, 0}, '{0, co, -so}, '{0, so, co}};
        ry = '{'{cp, 0, sp}, '{0, one, 0}, '{-sp, 0, cp}};
        rz = '{'{ck, -sk, 0}, '{sk, ck, 0}, '{0, 0, one}};
        q30_product(t, rx, ry, 0);
        q30_product(r, t, rz, 0);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic ematrix_t predict_essential(pose_pair_t p);
        ematrix_t res;
        longint unsigned mag [3], m, total, nrm;
        longint d, v;
        longint u [3];
        bit neg [3];
        int len;
        longint rl [3][3], rr [3][3], sk [3][3], t [3][3], e [3][3];
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            d = p.pos[3+i] - p.pos[i];
            neg[i] = d < 0;
            mag[i] = neg[i] ? -d : d;
            if (mag[i] > m) m = mag[i];
        end
        res.zb = (m == 0);
        foreach (res.ent[i]) res.ent[i] = '0;
        if (m == 0) return res;
        len = 0;
        while (len < 64 && (m >> len) != 0) len++;
        total = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (len > 30) mag[i] >>= (len - 30);
            else mag[i] <<= (30 - len);
            total += mag[i] * mag[i];
        end
        nrm = floor_sqrt(total);
        for (int i = 0; i < 3; i++)
        begin
            v = ((mag[i] << 30) + (nrm >> 1)) / nrm;
            u[i] = neg[i] ? -v : v;
        end
        sk = '{'{0, -u[2], u[1]}, '{u[2], 0, -u[0]}, '{-u[1], u[0], 0}};
        camera_rotation(p.ang[0], p.ang[1], p.ang[2], rl);
        camera_rotation(p.ang[3], p.ang[4], p.ang[5], rr);
        q30_product(t, rl, sk, 1);
        q30_product(e, t, rr, 0);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                v = e[i][j];
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                if (v < -64'sd2147483648) v = -64'sd2147483648;
                res.ent[i*3+j] = v[31:0];
            end
        return res;
    endfunction

    task automatic issue_pair(pose_pair_t p, int row, int gap);
        repeat (gap)
        begin
            @(posedge clk);
            start <= 1'b0;
        end
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b1;
        drive_row <= row;
        lpx <= p.pos[0]; lpy <= p.pos[1]; lpz <= p.pos[2];
        rpx <= p.pos[3]; rpy <= p.pos[4]; rpz <= p.pos[5];
        lom <= p.ang[0]; lph <= p.ang[1]; lka <= p.ang[2];
        rom <= p.ang[3]; rph <= p.ang[4]; rka <= p.ang[5];
    endtask

    // Acceptance is sampled at the edge, so the expectation enters the queue here.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            pose_pair_t p;
            p.pos = '{longint'(lpx), longint'(lpy), longint'(lpz),
                      longint'(rpx), longint'(rpy), longint'(rpz)};
            p.ang = '{longint'(lom), longint'(lph), longint'(lka),
                      longint'(rom), longint'(rph), longint'(rka)};
            if (drive_row >= 0 && dir_typed[drive_row])
                expected_q.push_back(dir_exp[drive_row]);
            else
                expected_q.push_back(predict_essential(p));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            ematrix_t exp_m;
            logic signed [31:0] got [9];
            got = '{e00, e01, e02, e10, e11, e12, e20, e21, e22};
            if (expected_q.size() == 0)
            begin
                $error("result with no item outstanding");
                mismatches++;
            end
            else
            begin
                exp_m = expected_q.pop_front();
                checked++;
                if (exp_m.zb) zero_count++;
                for (int i = 0; i < 9; i++)
                    if (got[i] !== exp_m.ent[i])
                    begin
                        $error("e_row%0d_col%0d: expected %0d, got %0d",
                               i / 3, i % 3, exp_m.ent[i], got[i]);
                        mismatches++;
                    end
                if (zbl !== exp_m.zb)
                begin
                    $error("zero_baseline: expected %0d, got %0d", exp_m.zb, zbl);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("essential_matrix_from_poses verification failed");
            $finish;
        end
    end

    function automatic longint rand_pos();
        longint v;
        case ($urandom_range(0, 3))
            0: v = {$urandom(), $urandom()};
            1: v = longint'($urandom_range(0, 2000)) - 1000;
            2: v = longint'($urandom_range(0, 200000000)) - 100000000;
            default: v = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
        endcase
        v = v <<< 24;
        return v >>> 24;
    endfunction

    function automatic longint rand_ang();
        longint v;
        v = $urandom();
        v = v <<< 40;
        return v >>> 40;
    endfunction

    function automatic pose_pair_t random_pair();
        pose_pair_t p;
        int shape;
        shape = $urandom_range(0, 9);
        for (int i = 0; i < 6; i++)
        begin
            p.pos[i] = rand_pos();
            p.ang[i] = rand_ang();
        end
        // Nearby cameras and coincident cameras, as in a real survey strip.
        if (shape < 4)
            for (int i = 0; i < 3; i++)
            begin
                p.pos[3+i] = p.pos[i] + longint'($urandom_range(0, 20000)) - 10000;
                if (p.pos[3+i] > POS_MAX || p.pos[3+i] < POS_MIN) p.pos[3+i] = p.pos[i];
            end
        else if (shape == 4)
            for (int i = 0; i < 3; i++) p.pos[3+i] = p.pos[i];
        return p;
    endfunction

    initial
    begin
        pose_pair_t p;
        for (int n = 0; n < NDIR; n++)
        begin
            dir_typed[n] = 1'b0;
            dir_exp[n].zb = 1'b0;
            foreach (dir_exp[n].ent[i]) dir_exp[n].ent[i] = '0;
            for (int i = 0; i < 6; i++)
            begin
                directed[n].pos[i] = 0;
                directed[n].ang[i] = 0;
            end
        end
        // Coincident cameras at the origin and at the extreme corners.
        for (int i = 0; i < 6; i++) directed[1].pos[i] = POS_MAX;
        for (int i = 0; i < 6; i++) directed[2].pos[i] = POS_MIN;
        // Coincident cameras give all-zero entries with the flag set.
        for (int n = 0; n < 3; n++)
        begin
            dir_typed[n] = 1'b1;
            dir_exp[n].zb = 1'b1;
        end
        // Baselines along each axis with no rotation.
        directed[3].pos[3] = 1000;
        directed[4].pos[4] = 1;
        directed[5].pos[5] = -7;
        // Widest possible baselines.
        for (int i = 0; i < 3; i++)
        begin
            directed[6].pos[i] = POS_MIN;
            directed[6].pos[3+i] = POS_MAX;
            directed[7].pos[i] = POS_MAX;
            directed[7].pos[3+i] = POS_MIN;
        end
        // Angle extremes, around plus and minus half pi, and near four radians.
        for (int n = 8; n < NDIR; n++) directed[n].pos[3] = 5000 + n;
        for (int i = 0; i < 6; i++)
        begin
            directed[8].ang[i] = ANG_MAX;
            directed[9].ang[i] = ANG_MIN;
            directed[10].ang[i] = (i % 2) ? 3294198 : -3294198;
            directed[11].ang[i] = (i % 2) ? 3294199 : -3294199;
            directed[12].ang[i] = (i % 2) ? 3294197 : -3294197;
            directed[13].ang[i] = (i < 3) ? 8388000 : -8388000;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int n = 0; n < NDIR; n++) issue_pair(directed[n], n, $urandom_range(0, 5));
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            p = random_pair();
            // Back-to-back bursts alternate with random gaps.
            issue_pair(p, -1, ((n / 100) % 3 == 0) ? 0 : $urandom_range(0, 5));
        end
        @(posedge clk);
        start <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Checked %0d essential matrices, %0d with coincident cameras.",
                 checked, zero_count);
        if (mismatches == 0)
            $display("essential_matrix_from_poses verification clean");
        else
            $display("essential_matrix_from_poses verification failed");
        $finish;
    end
endmodule
